@@ hw/rtl/lsct_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the stop table.
`default_nettype none

package lsct_pkg;

  localparam int NUM_STOPS = 10;
  localparam int IDX_W     = $clog2(NUM_STOPS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_STOPS - 1);

  localparam logic [15:0] STOP_SCALE = 16'd100;
  localparam logic [15:0] FULL_POS   = 16'hFFFF;
  localparam logic [15:0] STOP_LIMIT = 16'((NUM_STOPS - 1) * 100);

  // floor(x/100) by reciprocal: short form exact for x < 43699, long form for x < 2^23
  localparam logic [12:0] DIV100_RECIP_S = 13'd5243;
  localparam int          DIV100_SHIFT_S = 19;
  localparam logic [23:0] DIV100_RECIP_L = 24'd10737419;
  localparam int          DIV100_SHIFT_L = 30;

  // fraction divider: 7 quotient bits, anything at or above 128 saturates anyway
  localparam int DIV_STEPS = 7;
  localparam int STEP_W    = 3;

  localparam logic [2:0] REQ_CLEAR    = 3'd0;
  localparam logic [2:0] REQ_RECORD   = 3'd1;
  localparam logic [2:0] REQ_FINISH   = 3'd2;
  localparam logic [2:0] REQ_POS2STOP = 3'd3;
  localparam logic [2:0] REQ_STOP2POS = 3'd4;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_IDLE     = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
  localparam logic [OP_W-1:0] OP_CLEAR    = 5'd2;
  localparam logic [OP_W-1:0] OP_FINISH   = 5'd3;
  localparam logic [OP_W-1:0] OP_RECORD   = 5'd4;
  localparam logic [OP_W-1:0] OP_P_FIRST  = 5'd5;
  localparam logic [OP_W-1:0] OP_P_SEARCH = 5'd6;
  localparam logic [OP_W-1:0] OP_P_MUL    = 5'd7;
  localparam logic [OP_W-1:0] OP_P_SETUP  = 5'd8;
  localparam logic [OP_W-1:0] OP_P_DIV    = 5'd9;
  localparam logic [OP_W-1:0] OP_P_ANS    = 5'd10;
  localparam logic [OP_W-1:0] OP_S_CHK    = 5'd11;
  localparam logic [OP_W-1:0] OP_S_LO     = 5'd12;
  localparam logic [OP_W-1:0] OP_S_HI     = 5'd13;
  localparam logic [OP_W-1:0] OP_S_MUL    = 5'd14;
  localparam logic [OP_W-1:0] OP_S_ABS    = 5'd15;
  localparam logic [OP_W-1:0] OP_S_SCALE  = 5'd16;
  localparam logic [OP_W-1:0] OP_S_ANS    = 5'd17;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] addr;
    logic             out_load;
  } lsct_cmd_t;

  typedef struct packed {
    logic mapped;
    logic take;     // search: segment found here, or last segment reached
    logic too_big;  // stop number at or past the last entry
  } lsct_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/lsct_ctrl.sv @@
// Controller state machine: sequences table sweeps, segment search and arithmetic steps.
`default_nettype none

module lsct_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic [2:0]          req_type,
  input  wire logic [3:0]          stop_index,
  input  wire logic                out_stall,
  input  wire lsct_pkg::lsct_status_t status,
  output logic                     in_stall,
  output logic                     out_valid,
  output lsct_pkg::lsct_cmd_t      cmd
);
  import lsct_pkg::*;

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_CLEAR    = 5'd1;
  localparam logic [4:0] ST_FINISH   = 5'd2;
  localparam logic [4:0] ST_RECORD   = 5'd3;
  localparam logic [4:0] ST_P_FIRST  = 5'd4;
  localparam logic [4:0] ST_P_SEARCH = 5'd5;
  localparam logic [4:0] ST_P_MUL    = 5'd6;
  localparam logic [4:0] ST_P_SETUP  = 5'd7;
  localparam logic [4:0] ST_P_DIV    = 5'd8;
  localparam logic [4:0] ST_P_ANS    = 5'd9;
  localparam logic [4:0] ST_S_CHK    = 5'd10;
  localparam logic [4:0] ST_S_LO     = 5'd11;
  localparam logic [4:0] ST_S_HI     = 5'd12;
  localparam logic [4:0] ST_S_MUL    = 5'd13;
  localparam logic [4:0] ST_S_ABS    = 5'd14;
  localparam logic [4:0] ST_S_SCALE  = 5'd15;
  localparam logic [4:0] ST_S_ANS    = 5'd16;
  localparam logic [4:0] ST_DONE     = 5'd17;

  logic [4:0]        state, state_next;
  logic [IDX_W-1:0]  cnt, cnt_next;
  logic [STEP_W-1:0] step, step_next;
  logic [IDX_W-1:0]  idx_c;

  always_comb begin
    if (int'(stop_index) > NUM_STOPS - 1) begin
      idx_c = LAST_IDX;
    end else begin
      idx_c = IDX_W'(stop_index);
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    step_next    = step;
    cmd.op       = OP_IDLE;
    cmd.addr     = cnt;
    cmd.out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          unique case (req_type)
            REQ_CLEAR: begin
              cnt_next   = '0;
              state_next = ST_CLEAR;
            end
            REQ_RECORD: begin
              cnt_next   = idx_c;
              state_next = ST_RECORD;
            end
            REQ_FINISH: begin
              cnt_next   = idx_c;
              state_next = ST_FINISH;
            end
            REQ_POS2STOP: begin
              cnt_next   = '0;
              state_next = status.mapped ? ST_P_FIRST : ST_DONE;
            end
            REQ_STOP2POS: begin
              state_next = status.mapped ? ST_S_CHK : ST_DONE;
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_CLEAR, ST_FINISH: begin
        cmd.op = (state == ST_CLEAR) ? OP_CLEAR : OP_FINISH;
        if (cnt == LAST_IDX) begin
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + IDX_W'(1);
        end
      end
      ST_RECORD: begin
        cmd.op     = OP_RECORD;
        state_next = ST_DONE;
      end
      ST_P_FIRST: begin
        cmd.op     = OP_P_FIRST;
        cnt_next   = IDX_W'(1);
        state_next = ST_P_SEARCH;
      end
      ST_P_SEARCH: begin
        cmd.op = OP_P_SEARCH;
        if (status.take) begin
          state_next = ST_P_MUL;
        end else begin
          cnt_next = cnt + IDX_W'(1);
        end
      end
      ST_P_MUL: begin
        cmd.op     = OP_P_MUL;
        state_next = ST_P_SETUP;
      end
      ST_P_SETUP: begin
        cmd.op     = OP_P_SETUP;
        step_next  = '0;
        state_next = ST_P_DIV;
      end
      ST_P_DIV: begin
        cmd.op = OP_P_DIV;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_P_ANS;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      ST_P_ANS: begin
        cmd.op     = OP_P_ANS;
        state_next = ST_DONE;
      end
      ST_S_CHK: begin
        cmd.op     = OP_S_CHK;
        state_next = status.too_big ? ST_DONE : ST_S_LO;
      end
      ST_S_LO: begin
        cmd.op     = OP_S_LO;
        state_next = ST_S_HI;
      end
      ST_S_HI: begin
        cmd.op     = OP_S_HI;
        state_next = ST_S_MUL;
      end
      ST_S_MUL: begin
        cmd.op     = OP_S_MUL;
        state_next = ST_S_ABS;
      end
      ST_S_ABS: begin
        cmd.op     = OP_S_ABS;
        state_next = ST_S_SCALE;
      end
      ST_S_SCALE: begin
        cmd.op     = OP_S_SCALE;
        state_next = ST_S_ANS;
      end
      ST_S_ANS: begin
        cmd.op     = OP_S_ANS;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // hand over once the output register is free
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      step  <= step_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lsct_dp.sv @@
// Datapath: stop position registers, flags, search compare, divider and output register.
`default_nettype none

module lsct_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [15:0]         value,
  input  wire lsct_pkg::lsct_cmd_t cmd,
  output lsct_pkg::lsct_status_t   status,
  output logic [15:0]              answer,
  output logic                     is_mapped,
  output logic                     is_mapping
);
  import lsct_pkg::*;

  logic [15:0] stops [NUM_STOPS];
  logic        mapped, mapping;

  logic [15:0]        val_q, lo, hi, ans, quo;
  logic [IDX_W-1:0]   seg;
  logic signed [23:0] num, prod;
  logic signed [16:0] den;
  logic [22:0]        rem, dsh, mag;
  logic [6:0]         q, rem100;
  logic               ok, ovf, neg;

  logic [IDX_W-1:0]   rd_addr;
  logic [15:0]        rd;
  logic               last, take;
  logic signed [16:0] diff_p, span;
  logic [22:0]        num_abs;
  logic [15:0]        den_abs;
  logic               ge;
  logic [6:0]         frac;
  logic [28:0]        f_prod;
  logic [46:0]        quo_prod;

  // shared read port; stop-to-position reads at the segment found by the reciprocal
  always_comb begin
    if (cmd.op == OP_S_LO) begin
      rd_addr = seg;
    end else if (cmd.op == OP_S_HI) begin
      rd_addr = seg + IDX_W'(1);
    end else begin
      rd_addr = cmd.addr;
    end
  end

  assign rd     = stops[rd_addr];
  assign last   = (cmd.addr == LAST_IDX);
  assign take   = ((lo <= val_q) && (val_q < rd)) || last;
  assign diff_p = $signed({1'b0, val_q}) - $signed({1'b0, lo});
  assign span   = $signed({1'b0, hi}) - $signed({1'b0, lo});
  assign num_abs = num[23] ? 23'(-num) : num[22:0];
  assign den_abs = den[16] ? 16'(-den) : den[15:0];
  assign ge     = (rem >= dsh);
  assign f_prod   = 29'(val_q) * 29'(DIV100_RECIP_S);
  assign quo_prod = 47'(mag) * 47'(DIV100_RECIP_L);

  always_comb begin
    if (!ok) begin
      frac = '0;
    end else if (ovf || (q > 7'(STOP_SCALE))) begin
      frac = 7'(STOP_SCALE);
    end else begin
      frac = q;
    end
  end

  assign status.mapped  = mapped;
  assign status.take    = take;
  assign status.too_big = (val_q >= STOP_LIMIT);

  // table and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STOPS; i++) begin
        stops[i] <= '0;
      end
      mapped  <= 1'b0;
      mapping <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_CLEAR: begin
          stops[cmd.addr] <= '0;
          mapping         <= 1'b1;
        end
        OP_FINISH: begin
          stops[cmd.addr] <= FULL_POS;
          mapped          <= 1'b1;
          mapping         <= 1'b0;
        end
        OP_RECORD: stops[cmd.addr] <= val_q;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        val_q <= value;
        ans   <= '0;
      end
      OP_P_FIRST: lo <= rd;
      OP_P_SEARCH: begin
        if (take) begin
          hi  <= rd;
          seg <= cmd.addr - IDX_W'(1);
        end else begin
          lo <= rd;
        end
      end
      OP_P_MUL: begin
        num <= $signed(24'(diff_p)) * 24'sd100;
        den <= span;
      end
      OP_P_SETUP: begin
        rem <= num_abs;
        dsh <= {1'b0, den_abs, 6'd0};
        // quotient of 128 or more would saturate anyway
        ovf <= (num_abs >= {den_abs, 7'd0});
        // negative quotient clamps to zero, flat segment gives zero
        ok  <= (den != '0) && (num[23] == den[16]);
        q   <= '0;
      end
      OP_P_DIV: begin
        if (ge) begin
          rem <= rem - dsh;
        end
        q   <= {q[5:0], ge};
        dsh <= dsh >> 1;
      end
      OP_P_ANS: ans <= 16'(seg) * STOP_SCALE + 16'(frac);
      OP_S_CHK: begin
        if (status.too_big) begin
          ans <= stops[LAST_IDX];
        end else begin
          seg <= IDX_W'(f_prod >> DIV100_SHIFT_S);
        end
      end
      OP_S_LO: begin
        lo     <= rd;
        rem100 <= 7'(val_q - 16'(seg) * STOP_SCALE);
      end
      OP_S_HI: hi <= rd;
      OP_S_MUL: prod <= $signed(24'({1'b0, rem100})) * 24'(span);
      OP_S_ABS: begin
        mag <= prod[23] ? 23'(-prod) : prod[22:0];
        neg <= prod[23];
      end
      OP_S_SCALE: quo <= 16'(quo_prod >> DIV100_SHIFT_L);
      OP_S_ANS: ans <= neg ? (lo - quo) : (lo + quo);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      answer     <= ans;
      is_mapped  <= mapped;
      is_mapping <= mapping;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lens_stop_calibration_table_top.sv @@
// Lens stop calibration table: top level joining the controller and the datapath.
//
// Input channel (in_valid / in_stall) carries one request item: req_type, stop_index,
// value. Output channel (out_valid / out_stall) returns one item per request: answer,
// is_mapped, is_mapping (flags as they stand after the request).
// One request is in work at a time; in_stall is high from acceptance until the result
// is moved into the output register, and a new item is taken while that result waits.
// Work per request: record writes one entry, clear sweeps all NUM_STOPS entries, finish
//   fills from the index to the last entry, position to stop runs the segment search and
//   7 divider steps, stop to position reads two entries (stopping early past the last
//   stop), and an unmapped query or unknown code goes straight to the result.
// The linear segment search (one table read per cycle) and the bit-serial fraction
// divider make position to stop the longest request.
// Reset (rst, synchronous) zeroes the table, clears both flags and empties the output.
// While out_stall is high the result holds; a finished request waits for the register.
`default_nettype none

module lens_stop_calibration_table_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  req_type,
  input  wire logic [3:0]  stop_index,
  input  wire logic [15:0] value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      answer,
  output logic             is_mapped,
  output logic             is_mapping
);
  import lsct_pkg::*;

  lsct_cmd_t    cmd;
  lsct_status_t status;

  lsct_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .req_type   (req_type),
    .stop_index (stop_index),
    .out_stall  (out_stall),
    .status     (status),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .cmd        (cmd)
  );

  lsct_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .cmd        (cmd),
    .status     (status),
    .answer     (answer),
    .is_mapped  (is_mapped),
    .is_mapping (is_mapping)
  );

endmodule

`default_nettype wire

@@ hw/rtl/lsct_checker.sv @@
// Port-level checks for the stop table top level, attached by bind.
`default_nettype none

module lsct_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] answer,
  input wire logic        is_mapped,
  input wire logic        is_mapping
);

  // an accepted item keeps the input side closed while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not closed after item accepted");

  // result appears only at the end of work on an item
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without item in work");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(answer) && $stable(is_mapped)
                                  && $stable(is_mapping)))
    else $error("stalled result changed");

endmodule

bind lens_stop_calibration_table_top lsct_checker u_checker (.*);

`default_nettype wire

@@ bench/lsct_answer_checker.sv @@
// Checker for the stop table: tracks the table from accepted requests and checks each result.
`timescale 1ns / 1ps

module lsct_answer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [3:0]  stop_index,
  input  logic [15:0] value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] answer,
  input  logic        is_mapped,
  input  logic        is_mapping,
  output int          errors,
  output int          pending
);
  import lsct_pkg::*;

  typedef struct packed {
    logic [15:0] answer;
    logic        mapped;
    logic        mapping;
  } table_reply_t;

  logic [15:0]  tbl_pos [NUM_STOPS];
  logic         tbl_mapped;
  logic         tbl_mapping;
  table_reply_t replies_due [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic logic [15:0] pos_to_stop(logic [15:0] pos);
    int     seg;
    logic   found;
    longint lo, hi, frac;
    seg   = NUM_STOPS - 2;
    found = 1'b0;
    for (int i = 0; i < NUM_STOPS - 1; i++) begin
      if (!found && pos >= tbl_pos[i] && pos < tbl_pos[i+1]) begin
        seg   = i;
        found = 1'b1;
      end
    end
    lo = longint'(tbl_pos[seg]);
    hi = longint'(tbl_pos[seg+1]);
    // flat segment has no fraction; otherwise truncate toward zero, then saturate
    if (hi == lo) frac = 0;
    else frac = ((longint'(pos) - lo) * 100) / (hi - lo);
    if (frac < 0) frac = 0;
    if (frac > 100) frac = 100;
    return 16'(longint'(seg) * 100 + frac);
  endfunction

  function automatic logic [15:0] stop_to_pos(logic [15:0] stop);
    longint f, lo, hi, r;
    if (stop >= STOP_LIMIT) return tbl_pos[NUM_STOPS-1];
    if (stop == 16'd0) return tbl_pos[0];
    f  = longint'(stop) / 100;
    lo = longint'(tbl_pos[f]);
    hi = longint'(tbl_pos[f+1]);
    r  = ((longint'(stop) - f * 100) * (hi - lo)) / 100 + lo;
    return r[15:0];
  endfunction

  function automatic table_reply_t serve_request(logic [2:0] rq, logic [3:0] idx_in,
                                                 logic [15:0] val);
    table_reply_t rep;
    int           idx;
    rep.answer = '0;
    idx = (idx_in > NUM_STOPS - 1) ? NUM_STOPS - 1 : int'(idx_in);
    case (rq)
      REQ_CLEAR: begin
        for (int i = 0; i < NUM_STOPS; i++) tbl_pos[i] = '0;
        tbl_mapping = 1'b1;
      end
      REQ_RECORD: tbl_pos[idx] = val;
      REQ_FINISH: begin
        for (int i = idx; i < NUM_STOPS; i++) tbl_pos[i] = FULL_POS;
        tbl_mapped  = 1'b1;
        tbl_mapping = 1'b0;
      end
      REQ_POS2STOP: if (tbl_mapped) rep.answer = pos_to_stop(val);
      REQ_STOP2POS: if (tbl_mapped) rep.answer = stop_to_pos(val);
      default: ;
    endcase
    rep.mapped  = tbl_mapped;
    rep.mapping = tbl_mapping;
    return rep;
  endfunction

  always @(posedge clk) begin
    table_reply_t want;
    if (rst) begin
      for (int i = 0; i < NUM_STOPS; i++) tbl_pos[i] = '0;
      tbl_mapped  = 1'b0;
      tbl_mapping = 1'b0;
      replies_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result answer=%0d mapped=%0b mapping=%0b",
                     $realtime, answer, is_mapped, is_mapping);
        end else begin
          want = replies_due.pop_front();
          if (answer !== want.answer || is_mapped !== want.mapped ||
              is_mapping !== want.mapping) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch answer exp=%0d act=%0d",
                       $realtime, want.answer, answer,
                       " mapped exp=%0b act=%0b", want.mapped, is_mapped,
                       " mapping exp=%0b act=%0b", want.mapping, is_mapping);
          end
        end
      end
      if (in_valid && !in_stall)
        replies_due.push_back(serve_request(req_type, stop_index, value));
    end
    pending <= replies_due.size();
  end

endmodule

@@ bench/tb_lens_stop_calibration_table_top.sv @@
// Testbench top for the stop table: drives requests and stalls, gives the verdict.
`timescale 1ns / 1ps

module tb_lens_stop_calibration_table_top;
  import lsct_pkg::*;

  localparam int ITEM_TARGET = 1700;
  localparam int CYCLE_LIMIT = 1000000;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic [2:0]  req_type   = '0;
  logic [3:0]  stop_index = '0;
  logic [15:0] value      = '0;
  logic        out_stall  = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [15:0] answer;
  logic        is_mapped;
  logic        is_mapping;

  int          errors;
  int          pending;
  int          sent       = 0;
  int          cycles     = 0;
  logic        calm       = 1'b0;
  int          stall_left = 0;
  int          open_left  = 0;
  int          cal_pos [NUM_STOPS];

  always #10 clk = ~clk;

  lens_stop_calibration_table_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .stop_index (stop_index),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .answer     (answer),
    .is_mapped  (is_mapped),
    .is_mapping (is_mapping)
  );

  lsct_answer_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .stop_index (stop_index),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .answer     (answer),
    .is_mapped  (is_mapped),
    .is_mapping (is_mapping),
    .errors     (errors),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_lens_stop_calibration_table_top: FAIL");
      $finish;
    end
  end

  // receiver: bursts of stall, mostly short, off entirely in calm stretches
  always @(posedge clk) begin
    int r;
    if (rst || calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (open_left > 0) begin
      out_stall <= 1'b0;
      open_left--;
    end else begin
      r = $urandom_range(0, 99);
      stall_left = (r < 80) ? $urandom_range(1, 3) :
                   (r < 95) ? $urandom_range(4, 12) : $urandom_range(20, 60);
      open_left  = $urandom_range(0, 10);
      out_stall  <= 1'b0;
    end
  end

  task automatic send_item(input logic [2:0] rq, input int idx, input int val);
    int r, gap;
    r   = $urandom_range(0, 99);
    gap = calm ? 0 : (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= rq;
    stop_index <= 4'(idx);
    value      <= 16'(val);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_calibration();
    int k, style, scale, p, step, fin, n, j, v, r;
    send_item(REQ_CLEAR, $urandom_range(0, 15), $urandom);
    k     = $urandom_range(2, NUM_STOPS);
    style = $urandom_range(0, 9);
    r     = $urandom_range(0, 2);
    scale = (r == 0) ? 30 : (r == 1) ? 800 : 7000;
    p     = $urandom_range(0, 3000);
    for (int i = 0; i < k; i++) begin
      if (style == 0) begin
        p = $urandom_range(0, 65535);  // unordered table
      end else begin
        step = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, scale);
        p = (p + step > 65535) ? 65535 : p + step;
      end
      cal_pos[i] = p;
      send_item(REQ_RECORD, i, p);
    end
    for (int i = k; i < NUM_STOPS; i++) cal_pos[i] = 65535;
    fin = ($urandom_range(0, 9) == 0) ? $urandom_range(NUM_STOPS, 15) : k;
    send_item(REQ_FINISH, fin, $urandom);
    if (fin >= NUM_STOPS) cal_pos[NUM_STOPS-1] = 65535;
    n = $urandom_range(10, 40);
    for (int q = 0; q < n; q++) begin
      r = $urandom_range(0, 99);
      j = $urandom_range(0, NUM_STOPS - 2);
      if ($urandom_range(0, 1) == 0) begin
        if (r < 40) begin
          v = cal_pos[j] + $urandom_range(0, 4) - 2;
          v = (v < 0) ? 0 : (v > 65535) ? 65535 : v;
        end else if (r < 80) begin
          v = $urandom_range(cal_pos[j], cal_pos[j+1]);
        end else if (r < 90) begin
          v = ($urandom_range(0, 1) == 0) ? 0 : 65535;
        end else begin
          v = $urandom_range(0, 65535);
        end
        send_item(REQ_POS2STOP, $urandom_range(0, 15), v);
      end else begin
        v = (r < 50) ? $urandom_range(0, 999) :
            (r < 65) ? 100 * $urandom_range(0, NUM_STOPS) :
            (r < 75) ? 0 : $urandom_range(0, 65535);
        send_item(REQ_STOP2POS, $urandom_range(0, 15), v);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // queries and unknown codes before any calibration
    send_item(REQ_POS2STOP, 0, 1234);
    send_item(REQ_STOP2POS, 15, 500);
    for (int c = 1; c <= 3; c++) send_item(REQ_STOP2POS + 3'(c), 15, 65535);
    send_item(REQ_CLEAR, 0, 0);
    // ascending table with a flat segment between stops one and two
    cal_pos = '{1000, 3000, 3000, 9000, 12000, 20000, 30000, 40000, 50000, 60000};
    for (int i = 0; i < NUM_STOPS; i++) send_item(REQ_RECORD, i, cal_pos[i]);
    send_item(REQ_RECORD, 15, 65000);  // index clamps to the last stop
    send_item(REQ_FINISH, 15, 0);
    send_item(REQ_POS2STOP, 0, 0);       // below the table
    send_item(REQ_POS2STOP, 0, 65535);
    send_item(REQ_POS2STOP, 0, 3000);
    send_item(REQ_POS2STOP, 0, 10500);
    send_item(REQ_STOP2POS, 0, 0);
    send_item(REQ_STOP2POS, 0, 900);
    send_item(REQ_STOP2POS, 0, 65535);
    send_item(REQ_STOP2POS, 0, 150);
    send_item(REQ_STOP2POS, 0, 899);
    drain();

    while (sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 80) begin
        run_calibration();
      end else begin
        for (int i = 0; i < 10; i++)
          send_item(3'($urandom_range(0, 7)), $urandom_range(0, 15), $urandom_range(0, 65535));
      end
      if ($urandom_range(0, 99) < 15) drain();
    end

    drain();
    calm = 1'b0;
    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_lens_stop_calibration_table_top: PASS");
    end else begin
      $display("tb_lens_stop_calibration_table_top: FAIL");
    end
    $finish;
  end

endmodule
